// ===== hw/rtl/vdm_pkg.sv =====
`default_nettype none

package vdm_pkg;

   localparam int ELEM_W      = 16;
   localparam int DIFF_W      = ELEM_W + 1;
   localparam int WGT_W       = 16;
   localparam int NUM_WEIGHTS = 8;
   localparam int WIDX_W      = $clog2(NUM_WEIGHTS);
   localparam int MUL_A_W     = 2 * DIFF_W - 1;
   localparam int MUL_B_W     = DIFF_W;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = PROD_W + WIDX_W - 1;
   localparam int ROOT_SHIFT  = 8;
   localparam int ROOT_X_W    = ACC_W + ROOT_SHIFT;
   localparam int DIST_W      = 36;
   localparam int CNT_W       = 4;
   localparam int MODE_W      = 2;
   localparam int LEN_W       = 4;
   localparam int WORD_W      = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = WORD_W;

   localparam int DEFAULT_MAX_DIM = 8;

   localparam logic [WGT_W-1:0] ONE_WEIGHT    = 16'd256;
   localparam logic [LEN_W-1:0] LEN_RESET     = 4'd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_EUCLID     = 2'd0,
      MODE_MANHATTAN  = 2'd1,
      MODE_W_EUCLID   = 2'd2,
      MODE_W_MANHATTAN = 2'd3
   } metric_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_METRIC_MODE   = 2'd0,
      REG_VECTOR_LENGTH = 2'd1,
      REG_WEIGHTS_LOW   = 2'd2,
      REG_WEIGHTS_HIGH  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACC,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      metric_type                             mode;
      logic [LEN_W-1:0]                       length;
      logic [NUM_WEIGHTS-1:0][WGT_W-1:0]      weights;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic mul_en;
      logic mul_second;
      logic acc_en;
      logic root_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic manhattan;
      logic last;
      logic root_busy;
      logic out_free;
   } status_type;

   function automatic logic is_manhattan(metric_type m);
      return (m == MODE_MANHATTAN) || (m == MODE_W_MANHATTAN);
   endfunction

   function automatic logic is_weighted(metric_type m);
      return (m == MODE_W_EUCLID) || (m == MODE_W_MANHATTAN);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vdm_channels.sv =====
`default_nettype none

interface vdm_req_if;
   import vdm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] first_elem;
   logic signed [ELEM_W-1:0] second_elem;

   modport source (output valid, output first_elem, output second_elem, input ready);
   modport sink   (input valid, input first_elem, input second_elem, output ready);
endinterface

interface vdm_rsp_if;
   import vdm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;

   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

interface vdm_csr_if;
   import vdm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vdm_regs.sv =====
`default_nettype none

module vdm_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   vdm_csr_if.sink               csr_if,
   output vdm_pkg::cfg_type      cfg
);
   import vdm_pkg::*;

   metric_type        mode_ff, mode_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [WORD_W-1:0] wlow_ff, wlow_in;
   logic [WORD_W-1:0] whigh_ff, whigh_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      length_in = length_ff;
      wlow_in   = wlow_ff;
      whigh_in  = whigh_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            REG_METRIC_MODE:   mode_in   = metric_type'(csr_if.data[MODE_W-1:0]);
            REG_VECTOR_LENGTH: length_in = csr_if.data[LEN_W-1:0];
            REG_WEIGHTS_LOW:   wlow_in   = csr_if.data;
            REG_WEIGHTS_HIGH:  whigh_in  = csr_if.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_EUCLID;
         length_ff <= LEN_RESET;
         wlow_ff   <= '0;
         whigh_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         length_ff <= length_in;
         wlow_ff   <= wlow_in;
         whigh_ff  <= whigh_in;
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.length  = length_ff;
   assign cfg.weights = {whigh_ff, wlow_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/vdm_sqrt.sv =====
`default_nettype none

module vdm_sqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [vdm_pkg::ROOT_X_W-1:0]   operand,
   output logic                                busy,
   output logic [vdm_pkg::DIST_W-1:0]          root
);
   import vdm_pkg::*;

   logic [ROOT_X_W-1:0] x_ff, x_in;
   logic [ROOT_X_W-1:0] res_ff, res_in;
   logic [ROOT_X_W-1:0] bit_ff, bit_in;
   logic                busy_ff, busy_in;
   logic [ROOT_X_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   // One result bit per cycle, highest first.
   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = operand;
         res_in  = '0;
         bit_in  = {2'b01, {(ROOT_X_W-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[DIST_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/vdm_datapath.sv =====
`default_nettype none

module vdm_datapath #(
   parameter int MAX_DIM = vdm_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire vdm_pkg::cfg_type   cfg,
   input  wire vdm_pkg::cmd_type   cmd,
   output vdm_pkg::status_type     status,
   vdm_req_if.sink                 req_if,
   vdm_rsp_if.source               rsp_if
);
   import vdm_pkg::*;

   logic [LEN_W-1:0]   len_eff;
   logic [CNT_W-1:0]   count_ff, count_in, count_next;
   logic               accept;
   logic [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]  mag;
   logic [WGT_W-1:0]   weight;

   logic [DIFF_W-1:0]  mag_ff;
   logic [WGT_W-1:0]   w_ff;
   logic               manh_ff;
   logic               last_ff;

   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   logic               root_busy;
   logic [DIST_W-1:0]  root;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  dist_ff;
   logic               out_free;

   assign req_if.ready = cmd.take;
   assign accept       = req_if.valid && cmd.take;

   // Clamp the length: zero acts as one, anything above MAX_DIM as MAX_DIM.
   always_comb begin
      priority if (cfg.length == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.length > LEN_W'(MAX_DIM)) begin
         len_eff = LEN_W'(MAX_DIM);
      end else begin
         len_eff = cfg.length;
      end
   end

   assign count_next = count_ff + CNT_W'(1);
   assign count_in   = (count_next >= len_eff) ? '0 : count_next;

   assign diff   = {req_if.first_elem[ELEM_W-1], req_if.first_elem}
                 - {req_if.second_elem[ELEM_W-1], req_if.second_elem};
   assign mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
   assign weight = is_weighted(cfg.mode) ? cfg.weights[count_ff[WIDX_W-1:0]] : ONE_WEIGHT;

   // Shared multiplier: |d|*|d| or |d|*w first, then square*w in euclidean modes.
   assign op_a = cmd.mul_second ? prod_ff[MUL_A_W-1:0] : MUL_A_W'(mag_ff);
   assign op_b = (cmd.mul_second || manh_ff) ? MUL_B_W'(w_ff) : mag_ff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else if (cmd.out_load) begin
         acc_in = '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         mag_ff  <= mag;
         w_ff    <= weight;
         manh_ff <= is_manhattan(cfg.mode);
         last_ff <= (count_next >= len_eff);
      end
      if (cmd.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (cmd.out_load) begin
         dist_ff <= manh_ff ? acc_ff[DIST_W-1:0] : root;
      end
   end

   vdm_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.root_start),
      .operand ({acc_ff, {ROOT_SHIFT{1'b0}}}),
      .busy    (root_busy),
      .root    (root)
   );

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.distance = dist_ff;

   assign status.req_valid = req_if.valid;
   assign status.manhattan = manh_ff;
   assign status.last      = last_ff;
   assign status.root_busy = root_busy;
   assign status.out_free  = out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/vdm_ctrl.sv =====
`default_nettype none

module vdm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vdm_pkg::status_type  status,
   output vdm_pkg::cmd_type          cmd
);
   import vdm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.req_valid) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_en = 1'b1;
            state_in   = status.manhattan ? ST_ACC : ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_second = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            priority if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.manhattan) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ROOT_LOAD;
            end
         end
         ST_ROOT_LOAD: begin
            cmd.root_start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (!status.root_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register can take the result.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vector_distance_metric_unit.sv =====
`default_nettype none

// Channel  Role    Payload                              Moves when
// req_if   sink    first_elem, second_elem (s16 Q8.8)   valid & ready
// rsp_if   source  distance (u36, 16 fraction bits)     valid & ready
// csr_if   sink    index (2b), data (64b)               valid & ready (ready always high)
//
// Each element item is taken, multiplied and accumulated; euclidean modes use the
// single shared multiplier twice (square, then weight). The last element of a vector
// adds a finish step, and in euclidean modes first a root step: the iterative
// root unit produces one result bit per cycle (30 bits). Reset is synchronous:
// configuration returns to its defaults, sum and count clear. A result waits in the
// output register; items are taken meanwhile, until the next result must be loaded.

module vector_distance_metric_unit #(
   parameter int MAX_DIM = vdm_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic  clock,
   input  wire logic  reset,
   vdm_req_if.sink    req_if,
   vdm_rsp_if.source  rsp_if,
   vdm_csr_if.sink    csr_if
);
   import vdm_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   vdm_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   vdm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   vdm_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire
